FILE: src/baro_pressure_temperature_compensation_macros.svh
// assertion macros shared by the barometer compensation rtl
// depends on nothing; included by files that carry concurrent assertions
`ifndef BARO_PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BPTC_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bptc assertion failed");

// next-cycle implication, disabled while reset is low
`define BPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bptc assertion failed");

`endif

FILE: src/bptc_pkg.sv
// shared types and constants of the barometer compensation block
// no dependencies; imported by the register file, controller, datapath and top
`timescale 1ns / 1ps

package bptc_pkg;

  localparam int unsigned RawW   = 24;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned TempW  = 19;
  localparam int unsigned PresW  = 24;
  localparam int unsigned DtW    = 26;
  localparam int unsigned TstW   = 20;
  localparam int unsigned MulW   = 26;
  localparam int unsigned ProdW  = 52;
  localparam int unsigned WideW  = 42;
  localparam int unsigned AccW   = 64;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned ApbW   = 32;
  localparam int unsigned OutW   = 48;

  // temperature thresholds in hundredths of a degree
  localparam logic signed [TstW-1:0] TempRef     = 20'sd2000;
  localparam logic signed [TstW-1:0] TempVeryLow = -20'sd1500;

  // saturation bounds at working widths
  localparam logic signed [20:0] TempMin = -21'sd262144;
  localparam logic signed [20:0] TempMax = 21'sd262143;
  localparam logic signed [28:0] PresMin = -29'sd8388608;
  localparam logic signed [28:0] PresMax = 29'sd8388607;

  // calibration register indexes
  typedef enum logic [2:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_idx_e;

  // shared multiplier operand selection
  typedef enum logic [3:0] {
    MUL_NONE   = 4'd0,
    MUL_DT_C6  = 4'd1,
    MUL_DT_DT  = 4'd2,
    MUL_C4_DT  = 4'd3,
    MUL_C3_DT  = 4'd4,
    MUL_D_D    = 4'd5,
    MUL_E_E    = 4'd6,
    MUL_RAW_HI = 4'd7,
    MUL_RAW_LO = 4'd8
  } mul_sel_e;

  // datapath register update per step
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_DT      = 4'd1,
    OP_T1      = 4'd2,
    OP_TC      = 4'd3,
    OP_OFF     = 4'd4,
    OP_SENS    = 4'd5,
    OP_CORR1   = 4'd6,
    OP_CORR2   = 4'd7,
    OP_ACC_HI  = 4'd8,
    OP_ACC_SUM = 4'd9,
    OP_PRES    = 4'd10
  } dp_op_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    dp_op_e   op;
    logic     load_out;
  } bptc_cmd_t;

  typedef struct packed {
    logic [CoefW-1:0] c1;
    logic [CoefW-1:0] c2;
    logic [CoefW-1:0] c3;
    logic [CoefW-1:0] c4;
    logic [CoefW-1:0] c5;
    logic [CoefW-1:0] c6;
  } bptc_cal_t;

endpackage

FILE: src/bptc_regs.sv
// calibration register file behind the apb-style configuration port
// depends on bptc_pkg
`timescale 1ns / 1ps

module bptc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bptc_pkg::AddrW-1:0]  paddr,
  input  logic [bptc_pkg::ApbW-1:0]   pwdata,
  output logic [bptc_pkg::ApbW-1:0]   prdata,
  output logic                        pready,
  output bptc_pkg::bptc_cal_t         cal_o
);
  import bptc_pkg::*;

  bptc_cal_t cal_q;
  reg_idx_e  idx;
  logic      wr_en;

  assign idx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cal_o  = cal_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_C1:  cal_q.c1 <= pwdata[CoefW-1:0];
        REG_C2:  cal_q.c2 <= pwdata[CoefW-1:0];
        REG_C3:  cal_q.c3 <= pwdata[CoefW-1:0];
        REG_C4:  cal_q.c4 <= pwdata[CoefW-1:0];
        REG_C5:  cal_q.c5 <= pwdata[CoefW-1:0];
        REG_C6:  cal_q.c6 <= pwdata[CoefW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (idx)
      REG_C1:  prdata = {{(ApbW-CoefW){1'b0}}, cal_q.c1};
      REG_C2:  prdata = {{(ApbW-CoefW){1'b0}}, cal_q.c2};
      REG_C3:  prdata = {{(ApbW-CoefW){1'b0}}, cal_q.c3};
      REG_C4:  prdata = {{(ApbW-CoefW){1'b0}}, cal_q.c4};
      REG_C5:  prdata = {{(ApbW-CoefW){1'b0}}, cal_q.c5};
      REG_C6:  prdata = {{(ApbW-CoefW){1'b0}}, cal_q.c6};
      default: prdata = '0;
    endcase
  end

endmodule

FILE: src/bptc_dp.sv
// datapath: shared 26x26 multiplier, compensation state and output register
// depends on bptc_pkg; driven by bptc_ctrl through bptc_cmd_t
`timescale 1ns / 1ps

module bptc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bptc_pkg::bptc_cmd_t         cmd_i,
  input  bptc_pkg::bptc_cal_t         cal_i,
  input  logic [bptc_pkg::RawW-1:0]   raw_i,
  output logic [bptc_pkg::OutW-1:0]   out_o
);
  import bptc_pkg::*;

  // compensation state
  logic signed [DtW-1:0]   dt_q;
  logic signed [TstW-1:0]  t1_q;
  logic signed [TstW-1:0]  tc_q;
  logic signed [PresW-1:0] pres_q;

  // working registers
  logic [RawW-1:0]          raw_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [WideW-1:0]  off_q;
  logic signed [WideW-1:0]  sens_q;
  logic signed [AccW-1:0]   acc_q;
  logic [OutW-1:0]          out_q;

  logic signed [MulW-1:0]  mul_a;
  logic signed [MulW-1:0]  mul_b;
  logic signed [20:0]      d_w;
  logic signed [20:0]      e_w;
  logic                    low1;
  logic                    low2;
  logic signed [20:0]      tc_w;
  logic signed [20:0]      tc_c;
  logic signed [WideW-1:0] sq;
  logic signed [WideW-1:0] five_sq;
  logic signed [WideW-1:0] seven_sq;
  logic signed [WideW-1:0] eleven_sq;
  logic signed [43:0]      x_w;
  logic signed [28:0]      p_w;
  logic signed [28:0]      p_c;
  logic signed [AccW-1:0]  prod_ext;

  assign d_w  = $signed({t1_q[TstW-1], t1_q}) - 21'sd2000;
  assign e_w  = $signed({t1_q[TstW-1], t1_q}) + 21'sd1500;
  assign low1 = t1_q < TempRef;
  assign low2 = low1 && (tc_q < TempVeryLow);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_DT_C6: begin
        mul_a = dt_q;
        mul_b = $signed({{(MulW-CoefW){1'b0}}, cal_i.c6});
      end
      MUL_DT_DT: begin
        mul_a = dt_q;
        mul_b = dt_q;
      end
      MUL_C4_DT: begin
        mul_a = dt_q;
        mul_b = $signed({{(MulW-CoefW){1'b0}}, cal_i.c4});
      end
      MUL_C3_DT: begin
        mul_a = dt_q;
        mul_b = $signed({{(MulW-CoefW){1'b0}}, cal_i.c3});
      end
      MUL_D_D: begin
        mul_a = $signed({{5{d_w[20]}}, d_w});
        mul_b = $signed({{5{d_w[20]}}, d_w});
      end
      MUL_E_E: begin
        mul_a = $signed({{5{e_w[20]}}, e_w});
        mul_b = $signed({{5{e_w[20]}}, e_w});
      end
      MUL_RAW_HI: begin
        mul_a = $signed({2'b00, raw_q});
        mul_b = $signed({{4{sens_q[WideW-1]}}, sens_q[WideW-1:20]});
      end
      MUL_RAW_LO: begin
        mul_a = $signed({2'b00, raw_q});
        mul_b = $signed({6'b000000, sens_q[19:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // second-order temperature, saturated
  always_comb begin
    tc_w = $signed({t1_q[TstW-1], t1_q});
    if (low1) begin
      tc_w = $signed({t1_q[TstW-1], t1_q}) - $signed({3'b000, prod_q[48:31]});
    end
    if (tc_w < TempMin) begin
      tc_c = TempMin;
    end else if (tc_w > TempMax) begin
      tc_c = TempMax;
    end else begin
      tc_c = tc_w;
    end
  end

  // constant multiples of the squared terms
  assign sq        = $signed(prod_q[WideW-1:0]);
  assign five_sq   = (sq <<< 2) + sq;
  assign seven_sq  = (sq <<< 3) - sq;
  assign eleven_sq = (sq <<< 3) + (sq <<< 1) + sq;
  assign prod_ext  = $signed({{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q});

  // final pressure: (raw*sens >> 21) - off, then >> 15, saturated
  always_comb begin
    x_w = $signed({acc_q[AccW-1], acc_q[AccW-1:21]})
        - $signed({{2{off_q[WideW-1]}}, off_q});
    p_w = x_w[43:15];
    if (p_w < PresMin) begin
      p_c = PresMin;
    end else if (p_w > PresMax) begin
      p_c = PresMax;
    end else begin
      p_c = p_w;
    end
  end

  // stored temperature and pressure state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= '0;
      t1_q   <= '0;
      tc_q   <= '0;
      pres_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_DT:   dt_q   <= $signed({2'b00, raw_q}) - $signed({2'b00, cal_i.c5, 8'h00});
        OP_T1:   t1_q   <= TempRef + $signed(prod_q[42:23]);
        OP_TC:   tc_q   <= tc_c[TstW-1:0];
        OP_PRES: pres_q <= p_c[PresW-1:0];
        default: ;
      endcase
    end
  end

  // working registers and multiplier output
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load_in) begin
      raw_q <= raw_i;
    end
    if (cmd_i.load_out) begin
      out_q <= {{(OutW-PresW-TempW){1'b0}}, pres_q, tc_q[TempW-1:0]};
    end
    case (cmd_i.op)
      OP_OFF:     off_q  <= $signed({10'h000, cal_i.c2, 16'h0000}) + $signed(prod_q[48:7]);
      OP_SENS:    sens_q <= $signed({11'h000, cal_i.c1, 15'h0000}) + $signed(prod_q[49:8]);
      OP_CORR1: begin
        if (low1) begin
          off_q  <= off_q - (five_sq >>> 1);
          sens_q <= sens_q - (five_sq >>> 2);
        end
      end
      OP_CORR2: begin
        if (low2) begin
          off_q  <= off_q - seven_sq;
          sens_q <= sens_q - (eleven_sq >>> 1);
        end
      end
      OP_ACC_HI:  acc_q <= prod_ext;
      OP_ACC_SUM: acc_q <= (acc_q <<< 20) + prod_ext;
      default: ;
    endcase
  end

  assign out_o = out_q;

endmodule

FILE: src/bptc_ctrl.sv
// controller: one-hot sequencer that steps the datapath and owns the handshakes
// depends on bptc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "baro_pressure_temperature_compensation_macros.svh"

module bptc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_kind_i,
  output logic                 s_ready_o,
  input  logic                 m_ready_i,
  output logic                 m_valid_o,
  output bptc_pkg::bptc_cmd_t  cmd_o
);
  import bptc_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_DT    = 15'h0002,
    S_TMUL  = 15'h0004,
    S_T1    = 15'h0008,
    S_TC    = 15'h0010,
    S_PMUL  = 15'h0020,
    S_OFF   = 15'h0040,
    S_SENS  = 15'h0080,
    S_CORR1 = 15'h0100,
    S_CORR2 = 15'h0200,
    S_HI    = 15'h0400,
    S_LO    = 15'h0800,
    S_SUM   = 15'h1000,
    S_PRES  = 15'h2000,
    S_WB    = 15'h4000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   m_valid_q;
  logic   m_valid_d;
  logic   out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  // step sequence
  always_comb begin
    state_d        = state_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.op       = OP_NONE;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = s_kind_i ? S_PMUL : S_DT;
        end
      end
      S_DT: begin
        cmd_o.op = OP_DT;
        state_d  = S_TMUL;
      end
      S_TMUL: begin
        cmd_o.mul_sel = MUL_DT_C6;
        state_d       = S_T1;
      end
      S_T1: begin
        cmd_o.op      = OP_T1;
        cmd_o.mul_sel = MUL_DT_DT;
        state_d       = S_TC;
      end
      S_TC: begin
        cmd_o.op = OP_TC;
        state_d  = S_WB;
      end
      S_PMUL: begin
        cmd_o.mul_sel = MUL_C4_DT;
        state_d       = S_OFF;
      end
      S_OFF: begin
        cmd_o.op      = OP_OFF;
        cmd_o.mul_sel = MUL_C3_DT;
        state_d       = S_SENS;
      end
      S_SENS: begin
        cmd_o.op      = OP_SENS;
        cmd_o.mul_sel = MUL_D_D;
        state_d       = S_CORR1;
      end
      S_CORR1: begin
        cmd_o.op      = OP_CORR1;
        cmd_o.mul_sel = MUL_E_E;
        state_d       = S_CORR2;
      end
      S_CORR2: begin
        cmd_o.op = OP_CORR2;
        state_d  = S_HI;
      end
      S_HI: begin
        cmd_o.mul_sel = MUL_RAW_HI;
        state_d       = S_LO;
      end
      S_LO: begin
        cmd_o.op      = OP_ACC_HI;
        cmd_o.mul_sel = MUL_RAW_LO;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = OP_ACC_SUM;
        state_d  = S_PRES;
      end
      S_PRES: begin
        cmd_o.op = OP_PRES;
        state_d  = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // checks
  `BPTC_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, s_valid_i && s_ready_o, state_q == S_DT || state_q == S_PMUL)
  `BPTC_ASSERT(a_load_when_free, clk_i, rst_ni, cmd_o.load_out, !m_valid_q || m_ready_i)
  `BPTC_ASSERT_NEXT(a_load_sets_valid, clk_i, rst_ni, cmd_o.load_out, m_valid_q)
  `BPTC_ASSERT_NEXT(a_wb_waits, clk_i, rst_ni, state_q == S_WB && m_valid_q && !m_ready_i, state_q == S_WB)

endmodule

FILE: src/baro_pressure_temperature_compensation.sv
// Barometer compensation: one result beat per input beat, one item in flight.
// Temperature beat: steps S_DT, S_TMUL, S_T1 and S_TC, then S_WB loads the result.
// Pressure beat: S_PMUL, S_OFF, S_SENS, S_CORR1, S_CORR2, S_HI, S_LO, S_SUM, S_PRES, then S_WB.
// The steps are set by the single shared 26x26 multiplier and its sequencer.
// A waiting result sits in the output register while the next beat is taken.
// Async active-low reset clears calibration, stored temperature/pressure and control.
`timescale 1ns / 1ps

module baro_pressure_temperature_compensation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [bptc_pkg::RawW-1:0]   s_axis_tdata_i,   // [23:0] raw_sample
  input  logic [0:0]                  s_axis_tuser_i,   // [0] kind
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [bptc_pkg::OutW-1:0]   m_axis_tdata_o,   // [18:0] temperature_centi,
                                                        // [42:19] pressure_value
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bptc_pkg::AddrW-1:0]  paddr,
  input  logic [bptc_pkg::ApbW-1:0]   pwdata,
  output logic [bptc_pkg::ApbW-1:0]   prdata,
  output logic                        pready
);
  import bptc_pkg::*;

  bptc_cal_t cal;
  bptc_cmd_t cmd;

  // calibration words
  bptc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  // sequencer
  bptc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_kind_i  (s_axis_tuser_i[0]),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .cmd_o     (cmd)
  );

  // arithmetic
  bptc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cal_i  (cal),
    .raw_i  (s_axis_tdata_i),
    .out_o  (m_axis_tdata_o)
  );

endmodule

FILE: test/tb_top.sv
// self-checking testbench for baro_pressure_temperature_compensation
// predicts every result beat from its own model of the compensation math
// depends on bptc_pkg and the block's rtl only
`timescale 1ns / 1ps

module tb_top;
  import bptc_pkg::*;

  localparam logic        KindTemp      = 1'b0;
  localparam logic        KindPres      = 1'b1;
  localparam int unsigned NumCal        = REG_C6 + 1;
  localparam int unsigned UnusedReg     = NumCal;
  localparam int unsigned Phases        = 5;
  localparam int unsigned ItemsPerPhase = 136;
  localparam int unsigned StallCycles   = 400;
  localparam int unsigned IdlePercent   = 21;
  localparam int unsigned SettleCycles  = 20;

  // one result beat: compensated temperature and pressure
  typedef struct packed {
    logic signed [TempW-1:0] temp_centi;
    logic signed [PresW-1:0] pressure;
  } reading_t;

  // compensation predictor plus the store of readings still to arrive
  class compensation_checker;
    logic [CoefW-1:0]        cal [NumCal];
    logic signed [DtW-1:0]   temp_diff;
    logic signed [TstW-1:0]  first_temp;
    logic signed [TstW-1:0]  comp_temp;
    logic signed [PresW-1:0] comp_pres;
    reading_t                expected_readings [$];
    int unsigned             errors;

    function new();
      foreach (cal[i]) cal[i] = '0;
      temp_diff  = '0;
      first_temp = '0;
      comp_temp  = '0;
      comp_pres  = '0;
      errors     = 0;
    endfunction

    function void set_cal(int unsigned index, logic [CoefW-1:0] value);
      // writes past the last calibration word are dropped
      if (index < NumCal) cal[index] = value;
    endfunction

    function longint saturate(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // advance the predicted state by one accepted sample
    function void note_sample(logic kind, logic [RawW-1:0] raw);
      longint rv, dt, t1, tc, off, sens, d, sq, e, sq2, p;
      longint c1, c2, c3, c4, c5, c6;
      reading_t r;
      rv = raw;
      c1 = cal[REG_C1];
      c2 = cal[REG_C2];
      c3 = cal[REG_C3];
      c4 = cal[REG_C4];
      c5 = cal[REG_C5];
      c6 = cal[REG_C6];
      if (kind == KindTemp) begin
        dt = rv - c5 * 256;
        t1 = TempRef + ((dt * c6) >>> 23);
        tc = t1;
        // second-order correction below 20.00 degrees
        if (t1 < TempRef) tc = tc - ((dt * dt) >>> 31);
        temp_diff  = dt[DtW-1:0];
        first_temp = t1[TstW-1:0];
        comp_temp  = TstW'(saturate(tc, TempMin, TempMax));
      end else begin
        dt   = temp_diff;
        t1   = first_temp;
        tc   = comp_temp;
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        if (t1 < TempRef) begin
          d    = t1 - TempRef;
          sq   = d * d;
          off  = off - ((5 * sq) >>> 1);
          sens = sens - ((5 * sq) >>> 2);
          // very-low test on the compensated value, terms on first-order
          if (tc < TempVeryLow) begin
            e    = t1 - TempVeryLow;
            sq2  = e * e;
            off  = off - 7 * sq2;
            sens = sens - ((11 * sq2) >>> 1);
          end
        end
        p = (((rv * sens) >>> 21) - off) >>> 15;
        comp_pres = PresW'(saturate(p, PresMin, PresMax));
      end
      r.temp_centi = comp_temp[TempW-1:0];
      r.pressure   = comp_pres;
      expected_readings.push_back(r);
    endfunction

    function void check_reading(logic [OutW-1:0] data);
      reading_t want, got;
      got.temp_centi = data[TempW-1:0];
      got.pressure   = data[TempW+PresW-1:TempW];
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result beat, actual temp %0d pressure %0d",
                 $time, got.temp_centi, got.pressure);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.temp_centi !== want.temp_centi) begin
        $display("%0t: temperature mismatch, expected %0d actual %0d",
                 $time, want.temp_centi, got.temp_centi);
        errors++;
      end
      if (got.pressure !== want.pressure) begin
        $display("%0t: pressure mismatch, expected %0d actual %0d",
                 $time, want.pressure, got.pressure);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [RawW-1:0]  s_axis_tdata_i;   // [23:0] raw_sample
  logic [0:0]       s_axis_tuser_i;   // [0] kind
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [OutW-1:0]  m_axis_tdata_o;   // [18:0] temperature_centi, [42:19] pressure_value
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [ApbW-1:0]  pwdata;
  logic [ApbW-1:0]  prdata;
  logic             pready;

  compensation_checker sb = new();
  bit          no_gaps = 1'b0;
  int unsigned stall_requests = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;

  baro_pressure_temperature_compensation uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // result side: random backpressure, plus one long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_seen != stall_requests) begin
      stall_seen = stall_requests;
      stall_left = StallCycles;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= no_gaps || ($urandom_range(99, 0) >= IdlePercent);
    end
  end

  // check every result beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_reading(m_axis_tdata_o);
  end

  // calibration words with a typical factory spread
  function automatic logic [CoefW-1:0] typical_word(int unsigned index);
    case (index)
      REG_C1:  return 16'd40127;
      REG_C2:  return 16'd36924;
      REG_C3:  return 16'd23317;
      REG_C4:  return 16'd23282;
      REG_C5:  return 16'd33464;
      default: return 16'd28312;
    endcase
  endfunction

  // temperature reading scattered around the reference point
  function automatic logic [RawW-1:0] raw_near_ref();
    longint      v;
    int unsigned span;
    span = $urandom_range(23, 6);
    v = longint'(sb.cal[REG_C5]) * 256 + longint'($urandom_range((1 << span) - 1, 0))
        - longint'(1 << (span - 1));
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[RawW-1:0];
  endfunction

  function automatic logic [RawW-1:0] random_pres_raw();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return RawW'(6465444 + $urandom_range(1 << 21, 0) - (1 << 20));
      default: return RawW'($urandom_range(24'hFFFFFF, 0));
    endcase
  endfunction

  // offer one sample, optionally after a short gap, and wait for the beat
  task automatic send_sample(input logic kind, input logic [RawW-1:0] raw);
    if (!no_gaps && $urandom_range(99, 0) < IdlePercent) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= raw;
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(kind, raw);
  endtask

  // stop offering until every expected reading has come out
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // apb write: setup cycle, access cycle, then idle
  task automatic write_reg(input int unsigned index, input logic [CoefW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(index * 4);
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_cal(index, value);
    @(posedge clk_i);
  endtask

  // per-phase calibration: typical, random mixes, all ones, all zeros
  task automatic load_calibration(input int unsigned ph);
    logic [CoefW-1:0] w;
    for (int unsigned i = 0; i < NumCal; i++) begin
      case (ph)
        0: w = typical_word(i) + CoefW'($urandom_range(255, 0)) - 16'd128;
        2: w = '1;
        3: w = '0;
        default: begin
          case ($urandom_range(3, 0))
            0:       w = '0;
            1:       w = '1;
            default: w = CoefW'($urandom);
          endcase
        end
      endcase
      write_reg(i, w);
    end
    write_reg(UnusedReg + $urandom_range(1, 0), CoefW'($urandom));
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    bit          held;
    bit          paused;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pressure before any temperature, calibration still at reset
    send_sample(KindPres, 24'hFFFFFF);
    send_sample(KindTemp, 24'h000000);
    send_sample(KindPres, 24'h000000);
    wait_drained();
    for (int unsigned i = 0; i < NumCal; i++) write_reg(i, typical_word(i));
    write_reg(UnusedReg, 16'hA5A5);

    // below 20.00 degrees but not very low
    send_sample(KindTemp, 24'd8077636);
    send_sample(KindPres, 24'd6465444);
    // exactly at the 20.00 degree threshold
    send_sample(KindTemp, {typical_word(REG_C5), 8'h00});
    send_sample(KindPres, 24'd6465444);
    // low but not very low
    send_sample(KindTemp, 24'd8270784);
    send_sample(KindPres, 24'd6465444);
    // very cold
    send_sample(KindTemp, 24'h000000);
    send_sample(KindPres, 24'h000000);
    send_sample(KindPres, 24'hFFFFFF);
    // hottest raw value
    send_sample(KindTemp, 24'hFFFFFF);
    send_sample(KindPres, 24'hFFFFFF);
    send_sample(KindPres, 24'h000000);
    wait_drained();

    // all calibration words at full scale
    for (int unsigned i = 0; i < NumCal; i++) write_reg(i, '1);
    send_sample(KindTemp, 24'h000000);
    send_sample(KindPres, 24'hFFFFFF);
    send_sample(KindTemp, 24'hFFFFFF);
    send_sample(KindPres, 24'hFFFFFF);
    send_sample(KindPres, 24'h000000);
    wait_drained();

    // first-order near 20 degrees, second-order pushes it very low
    write_reg(REG_C6, 16'h0001);
    send_sample(KindTemp, 24'h000000);
    send_sample(KindPres, 24'hFFFFFF);

    // random phases: mostly temperature then pressure runs
    for (int unsigned ph = 0; ph < Phases; ph++) begin
      wait_drained();
      repeat (SettleCycles) @(posedge clk_i);
      load_calibration(ph);
      no_gaps = (ph == 2);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if (ph == 1 && sent >= 40 && !held) begin
          stall_requests = stall_requests + 1;
          held = 1'b1;
        end
        if (ph == 3 && sent >= 70 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(99, 0) < 75) begin
          send_sample(KindTemp, raw_near_ref());
          n = $urandom_range(3, 1);
          repeat (n) send_sample(KindPres, random_pres_raw());
          sent = sent + 1 + n;
        end else begin
          send_sample(1'($urandom_range(1, 0)), RawW'($urandom_range(24'hFFFFFF, 0)));
          sent = sent + 1;
        end
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS baro_pressure_temperature_compensation");
    end else begin
      $display("FAIL baro_pressure_temperature_compensation");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(5_000_000);
    $display("FAIL baro_pressure_temperature_compensation");
    $finish;
  end

endmodule
